// File: rtl/core/oaht_pkg.sv
package oaht_pkg;

   localparam int TABLE_SLOTS = 1024;
   localparam int KEY_BITS    = 32;
   localparam int IDX_BITS    = $clog2(TABLE_SLOTS);
   localparam int CNT_BITS    = $clog2(TABLE_SLOTS + 1);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_EMPTY    = 2'd0,
      ST_OCCUPIED = 2'd1,
      ST_REMOVED  = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] key;
      logic [9:0]  home_hash;
   } req_type;

   typedef struct packed {
      logic        success;
      logic [10:0] slot_index;
      logic [10:0] element_count;
   } rsp_type;

   typedef struct packed {
      opcode_type            op;
      logic [KEY_BITS-1:0]   key;
      logic [IDX_BITS-1:0]   home;
   } cmd_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_READ,
      BK_EVAL,
      BK_SCAN_READ,
      BK_SCAN_EVAL,
      BK_WRITE,
      BK_CLEAR,
      BK_DONE
   } back_state_type;

endpackage

// File: rtl/core/oaht_front.sv
module oaht_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  oaht_pkg::req_type  req_data,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output oaht_pkg::cmd_type  cmd_data
);

   oaht_pkg::cmd_type q_ff [2];
   oaht_pkg::cmd_type q_in;
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        fill_ff;
   logic              push, pop;

   assign req_ready = (fill_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      q_in.op   = oaht_pkg::opcode_type'(req_data.opcode);
      q_in.key  = req_data.key[oaht_pkg::KEY_BITS-1:0];
      q_in.home = oaht_pkg::IDX_BITS'(oaht_pkg::CNT_BITS'(req_data.home_hash)
                  % oaht_pkg::CNT_BITS'(oaht_pkg::TABLE_SLOTS));
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         fill_ff <= fill_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

// File: rtl/core/oaht_back.sv
module oaht_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   output logic               cmd_ready,
   input  oaht_pkg::cmd_type  cmd_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output oaht_pkg::rsp_type  rsp_data
);

   localparam int IB = oaht_pkg::IDX_BITS;
   localparam int CB = oaht_pkg::CNT_BITS;
   localparam int KB = oaht_pkg::KEY_BITS;

   logic [1:0]    stat_mem [oaht_pkg::TABLE_SLOTS];
   logic [KB-1:0] key_mem  [oaht_pkg::TABLE_SLOTS];
   logic [1:0]    stat_rd_ff;
   logic [KB-1:0] key_rd_ff;

   oaht_pkg::back_state_type state_ff, state_in;
   oaht_pkg::cmd_type        cmd_ff;
   logic [IB-1:0] pos_ff, pos_in, fill_pos_ff, fill_pos_in, clr_ff, clr_in;
   logic [IB:0]   probe_ff, probe_in;
   logic [CB-1:0] count_ff, count_in;
   logic          success_ff, success_in;
   logic [10:0]   slot_ff, slot_in;
   logic          init_ff, init_in;

   logic          st_we;
   logic [IB-1:0] st_addr;
   logic [1:0]    st_wdata;
   logic          key_we;
   logic [IB-1:0] rd_addr;
   logic          hit, last, rsp_valid_ff, rsp_valid_in;
   logic [IB:0]   probe_nx;
   logic [IB-1:0] pos_nx;

   assign hit      = (stat_rd_ff == oaht_pkg::ST_OCCUPIED) && (key_rd_ff == cmd_ff.key);
   assign probe_nx = probe_ff + 1'b1;
   assign pos_nx   = pos_ff + probe_nx[IB-1:0];
   assign last     = (probe_nx == (IB+1)'(oaht_pkg::TABLE_SLOTS));
   assign cmd_ready = (state_ff == oaht_pkg::BK_IDLE) && !init_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rd_addr   = pos_ff;

   always_ff @(posedge clock) begin
      if (st_we) stat_mem[st_addr] <= st_wdata;
      if (key_we) key_mem[fill_pos_ff] <= cmd_ff.key;
      stat_rd_ff <= stat_mem[rd_addr];
      key_rd_ff  <= key_mem[rd_addr];
   end

   always_comb begin
      state_in    = state_ff;
      pos_in      = pos_ff;
      fill_pos_in = fill_pos_ff;
      probe_in    = probe_ff;
      count_in    = count_ff;
      success_in  = success_ff;
      slot_in     = slot_ff;
      clr_in      = clr_ff;
      init_in     = init_ff;
      rsp_valid_in = rsp_valid_ff;
      st_we       = 1'b0;
      st_addr     = pos_ff;
      st_wdata    = oaht_pkg::ST_REMOVED;
      key_we      = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (init_ff) begin
         st_we    = 1'b1;
         st_addr  = clr_ff;
         st_wdata = oaht_pkg::ST_EMPTY;
         clr_in   = clr_ff + 1'b1;
         if (clr_ff == IB'(oaht_pkg::TABLE_SLOTS - 1)) init_in = 1'b0;
      end
      unique case (state_ff)
         oaht_pkg::BK_IDLE: begin
            if (cmd_valid && !init_ff) begin
               pos_in     = cmd_data.home;
               probe_in   = '0;
               success_in = 1'b0;
               slot_in    = 11'(oaht_pkg::TABLE_SLOTS);
               clr_in     = '0;
               state_in   = (cmd_data.op == oaht_pkg::OP_CLEAR) ? oaht_pkg::BK_CLEAR
                                                                 : oaht_pkg::BK_READ;
            end
         end
         oaht_pkg::BK_READ: state_in = oaht_pkg::BK_EVAL;
         oaht_pkg::BK_EVAL: begin
            if (cmd_ff.op == oaht_pkg::OP_INSERT) begin
               if (hit) begin
                  state_in = oaht_pkg::BK_DONE;
               end else if (stat_rd_ff == oaht_pkg::ST_EMPTY) begin
                  fill_pos_in = pos_ff;
                  state_in    = oaht_pkg::BK_WRITE;
               end else if (stat_rd_ff == oaht_pkg::ST_REMOVED) begin
                  fill_pos_in = pos_ff;
                  if (last) begin
                     state_in = oaht_pkg::BK_WRITE;
                  end else begin
                     probe_in = probe_nx;
                     pos_in   = pos_nx;
                     state_in = oaht_pkg::BK_SCAN_READ;
                  end
               end else if (last) begin
                  state_in = oaht_pkg::BK_DONE;
               end else begin
                  probe_in = probe_nx;
                  pos_in   = pos_nx;
                  state_in = oaht_pkg::BK_READ;
               end
            end else begin
               if (stat_rd_ff == oaht_pkg::ST_EMPTY || last && !hit) begin
                  state_in = oaht_pkg::BK_DONE;
               end else if (hit) begin
                  success_in = 1'b1;
                  slot_in    = 11'(pos_ff);
                  if (cmd_ff.op == oaht_pkg::OP_REMOVE) begin
                     st_we    = 1'b1;
                     count_in = count_ff - CB'(count_ff != '0);
                  end
                  state_in = oaht_pkg::BK_DONE;
               end else begin
                  probe_in = probe_nx;
                  pos_in   = pos_nx;
                  state_in = oaht_pkg::BK_READ;
               end
            end
         end
         oaht_pkg::BK_SCAN_READ: state_in = oaht_pkg::BK_SCAN_EVAL;
         oaht_pkg::BK_SCAN_EVAL: begin
            if (hit) begin
               st_we    = 1'b1;
               count_in = count_ff - CB'(count_ff != '0);
               state_in = oaht_pkg::BK_WRITE;
            end else if (stat_rd_ff == oaht_pkg::ST_EMPTY || last) begin
               state_in = oaht_pkg::BK_WRITE;
            end else begin
               probe_in = probe_nx;
               pos_in   = pos_nx;
               state_in = oaht_pkg::BK_SCAN_READ;
            end
         end
         oaht_pkg::BK_WRITE: begin
            st_we      = 1'b1;
            st_addr    = fill_pos_ff;
            st_wdata   = oaht_pkg::ST_OCCUPIED;
            key_we     = 1'b1;
            count_in   = count_in + 1'b1;
            success_in = 1'b1;
            slot_in    = 11'(fill_pos_ff);
            state_in   = oaht_pkg::BK_DONE;
         end
         oaht_pkg::BK_CLEAR: begin
            st_we    = 1'b1;
            st_addr  = clr_ff;
            clr_in   = clr_ff + 1'b1;
            if (clr_ff == IB'(oaht_pkg::TABLE_SLOTS - 1)) begin
               count_in   = '0;
               success_in = 1'b1;
               state_in   = oaht_pkg::BK_DONE;
            end
         end
         oaht_pkg::BK_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in     = oaht_pkg::BK_IDLE;
            end
         end
         default: state_in = oaht_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (state_ff == oaht_pkg::BK_IDLE && cmd_valid) cmd_ff <= cmd_data;
      if (state_ff == oaht_pkg::BK_DONE && (!rsp_valid_ff || rsp_ready)) begin
         rsp_data.success       <= success_ff;
         rsp_data.slot_index    <= slot_ff;
         rsp_data.element_count <= 11'(count_ff);
      end
      pos_ff      <= pos_in;
      fill_pos_ff <= fill_pos_in;
      probe_ff    <= probe_in;
      success_ff  <= success_in;
      slot_ff     <= slot_in;
      if (reset) begin
         state_ff     <= oaht_pkg::BK_IDLE;
         count_ff     <= '0;
         clr_ff       <= '0;
         init_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         clr_ff       <= clr_in;
         init_ff      <= init_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: rtl/core/open_address_hash_table.sv
// Open-addressing key set with triangular probing over 1024 slots.
// Requests arrive on req_valid/req_ready with a req_data struct holding the
// opcode, the key and its precomputed home slot; one result per request
// leaves on rsp_valid/rsp_ready as a rsp_data struct.
// A two-entry queue separates the request side from the execution engine,
// so up to two further transactions are taken while one is being executed.
// Each probe is a registered memory read followed by a decision; an insert
// that meets a tombstone keeps probing for a later copy of the key. A clear
// sweeps every slot, one per cycle.
// After reset the engine marks every slot empty; the queue accepts requests
// meanwhile but none is executed until it ends.
// A stalled result is held in the output register; the engine waits with
// the next result until it is taken, and the queue then backs up.
module open_address_hash_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oaht_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output oaht_pkg::rsp_type rsp_data
);

   logic              cmd_valid, cmd_ready;
   oaht_pkg::cmd_type cmd_data;

   oaht_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   oaht_back u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

`ifndef SYNTHESIS
   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.slot_index <= 11'(oaht_pkg::TABLE_SLOTS))
      else $error("slot index out of range");
   a_fail_noslot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.success |-> rsp_data.slot_index == 11'(oaht_pkg::TABLE_SLOTS))
      else $error("failed result reports a slot");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.element_count <= 11'(oaht_pkg::TABLE_SLOTS))
      else $error("element count out of range");
`endif

endmodule

// File: dv/tb_open_address_hash_table.sv
`timescale 1ns / 100ps

module tb_open_address_hash_table;
   import oaht_pkg::*;

   localparam int SLOTS      = TABLE_SLOTS;
   localparam int POOL_SIZE  = 48;
   localparam int PHASE_LEN  = 510;
   localparam int STALL_MAX  = 20000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   open_address_hash_table uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   status_type  shadow_status [SLOTS];
   logic [31:0] shadow_key    [SLOTS];
   int unsigned shadow_count;

   req_type     pending_reqs [$];
   rsp_type     expected_rsps [$];
   int          send_idle_pct;
   int          recv_idle_pct;
   int          fail_count;
   int          quiet_cycles;
   logic [31:0] pool_key  [POOL_SIZE];
   logic [9:0]  pool_home [POOL_SIZE];
   logic [9:0]  buckets   [8];

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   function automatic bit holds_key(int unsigned s, logic [31:0] k);
      return shadow_status[s] == ST_OCCUPIED && shadow_key[s] == k;
   endfunction

   function automatic int unsigned locate_key(int unsigned home, logic [31:0] k,
                                              int unsigned first);
      int unsigned pos;
      pos = home;
      for (int unsigned i = 1; i <= first && i < SLOTS; i++)
         pos = (pos + i) % SLOTS;
      for (int unsigned i = first; i < SLOTS; i++) begin
         if (i != first)
            pos = (pos + i) % SLOTS;
         if (shadow_status[pos] == ST_EMPTY)
            return SLOTS;
         if (holds_key(pos, k))
            return pos;
      end
      return SLOTS;
   endfunction

   function automatic void mark_removed(int unsigned s);
      shadow_status[s] = ST_REMOVED;
      if (shadow_count > 0)
         shadow_count--;
   endfunction

   function automatic int unsigned insert_key(int unsigned home, logic [31:0] k);
      int unsigned pos;
      int unsigned i;
      int unsigned later;
      pos = home;
      for (i = 0; i < SLOTS; i++) begin
         if (i != 0)
            pos = (pos + i) % SLOTS;
         if (holds_key(pos, k))
            return SLOTS;
         if (shadow_status[pos] == ST_EMPTY)
            break;
         if (shadow_status[pos] == ST_REMOVED) begin
            if (i + 1 < SLOTS) begin
               later = locate_key(home, k, i + 1);
               if (later < SLOTS)
                  mark_removed(later);
            end
            break;
         end
      end
      if (i >= SLOTS)
         return SLOTS;
      shadow_status[pos] = ST_OCCUPIED;
      shadow_key[pos]    = k;
      shadow_count++;
      return pos;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type     res;
      int unsigned s;
      int unsigned home;
      home = r.home_hash % SLOTS;
      s    = SLOTS;
      res.success = 1'b0;
      case (opcode_type'(r.opcode))
         OP_LOOKUP: s = locate_key(home, r.key, 0);
         OP_INSERT: s = insert_key(home, r.key);
         OP_REMOVE: begin
            s = locate_key(home, r.key, 0);
            if (s < SLOTS)
               mark_removed(s);
         end
         default: begin
            foreach (shadow_status[n])
               shadow_status[n] = ST_REMOVED;
            shadow_count = 0;
         end
      endcase
      res.success       = (opcode_type'(r.opcode) == OP_CLEAR) ? 1'b1 : (s < SLOTS);
      res.slot_index    = 11'(s);
      res.element_count = 11'(shadow_count);
      return res;
   endfunction

   function automatic req_type make_req(opcode_type op, logic [31:0] k, logic [9:0] h);
      req_type r;
      r.opcode    = op;
      r.key       = k;
      r.home_hash = h;
      return r;
   endfunction

   function automatic req_type random_req();
      int unsigned roll;
      int unsigned idx;
      opcode_type  op;
      roll = $urandom_range(0, 99);
      idx  = $urandom_range(0, POOL_SIZE - 1);
      if (roll < 10)
         return make_req(opcode_type'($urandom_range(0, 2)), $urandom(),
                         10'($urandom_range(0, 1023)));
      roll = $urandom_range(0, 99);
      if (roll < 35)
         op = OP_LOOKUP;
      else if (roll < 75)
         op = OP_INSERT;
      else
         op = OP_REMOVE;
      return make_req(op, pool_key[idx], pool_home[idx]);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else if (!req_valid || req_ready) begin
         if (req_valid)
            expected_rsps.push_back(apply_request(req_data));
         if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_MAX) begin
            $display("Verification failed");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected result, actual %p", $time, rsp_data);
               fail_count++;
            end else begin
               if (rsp_data.success !== expected_rsps[0].success ||
                   rsp_data.slot_index !== expected_rsps[0].slot_index ||
                   rsp_data.element_count !== expected_rsps[0].element_count) begin
                  $display("%0t: mismatch, expected %p, actual %p",
                           $time, expected_rsps[0], rsp_data);
                  fail_count++;
               end
               void'(expected_rsps.pop_front());
            end
         end
      end
   end

   task automatic drain();
      while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      fail_count    = 0;
      send_idle_pct = 9;
      recv_idle_pct = 82;
      reset         = 1'b1;
      foreach (shadow_status[n]) begin
         shadow_status[n] = ST_EMPTY;
         shadow_key[n]    = '0;
      end
      shadow_count = 0;
      foreach (buckets[b])
         buckets[b] = 10'($urandom_range(0, 1023));
      foreach (pool_key[p]) begin
         pool_key[p]  = $urandom();
         pool_home[p] = buckets[$urandom_range(0, 7)];
      end
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      pending_reqs.push_back(make_req(OP_LOOKUP, 32'h0, 10'd0));
      pending_reqs.push_back(make_req(OP_INSERT, 32'h0, 10'd0));
      pending_reqs.push_back(make_req(OP_INSERT, 32'hFFFF_FFFF, 10'd0));
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'hFFFF_FFFF, 10'd0));
      pending_reqs.push_back(make_req(OP_INSERT, 32'hA5A5_0001, 10'd1023));
      pending_reqs.push_back(make_req(OP_INSERT, 32'h5A5A_0002, 10'd1023));
      pending_reqs.push_back(make_req(OP_INSERT, 32'h5A5A_0002, 10'd1023));
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'h5A5A_0002, 10'd1023));
      pending_reqs.push_back(make_req(OP_REMOVE, 32'hA5A5_0001, 10'd1023));
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'hA5A5_0001, 10'd1023));
      pending_reqs.push_back(make_req(OP_INSERT, 32'h5A5A_0002, 10'd1023));
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'h5A5A_0002, 10'd1023));
      pending_reqs.push_back(make_req(OP_REMOVE, 32'h1234_5678, 10'd512));
      pending_reqs.push_back(make_req(OP_REMOVE, 32'h0, 10'd0));
      pending_reqs.push_back(make_req(OP_LOOKUP, 32'h0, 10'd0));
      drain();

      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 82 : 0;
         recv_idle_pct = (ph == 0) ? 82 : (ph == 1) ? 9 : 0;
         for (int n = 0; n < PHASE_LEN; n++)
            pending_reqs.push_back(random_req());
         drain();
      end

      // Clearing leaves every slot a tombstone, so later probes run the full
      // sequence; this part is kept short and placed last.
      send_idle_pct = 9;
      recv_idle_pct = 50;
      pending_reqs.push_back(make_req(OP_CLEAR, 32'h0, 10'd0));
      pending_reqs.push_back(make_req(OP_LOOKUP, pool_key[0], pool_home[0]));
      pending_reqs.push_back(make_req(OP_INSERT, pool_key[0], pool_home[0]));
      pending_reqs.push_back(make_req(OP_INSERT, pool_key[0], pool_home[0]));
      pending_reqs.push_back(make_req(OP_LOOKUP, pool_key[0], pool_home[0]));
      pending_reqs.push_back(make_req(OP_INSERT, pool_key[1], pool_home[1]));
      pending_reqs.push_back(make_req(OP_REMOVE, pool_key[0], pool_home[0]));
      pending_reqs.push_back(make_req(OP_CLEAR, 32'hFFFF_FFFF, 10'd1023));
      pending_reqs.push_back(make_req(OP_LOOKUP, pool_key[1], pool_home[1]));
      drain();
      repeat (100) @(posedge clock);

      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
